// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion macros for the framer rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never hold outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/bsif_pkg.sv =====
// ----------------------------------------------------------------------------
// bsif_pkg
// shared types and constants of the byte stuffing info framer
// ----------------------------------------------------------------------------
`default_nettype none

package bsif_pkg;

   localparam logic [7:0] FLAG_BYTE = 8'h7E;
   localparam logic [7:0] ESC_BYTE  = 8'h7D;
   localparam logic [7:0] ESC_MASK  = 8'h20;

   localparam logic [7:0] ADDRESS_RESET = 8'h03;
   localparam logic [7:0] CONTROL_RESET = 8'h00;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ADDRESS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONTROL = 1'd1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic       header;
      logic       last;
      logic [7:0] address;
      logic [7:0] control;
      logic [7:0] data;
      logic [7:0] check;
   } job_type;

   function automatic logic needs_escape(input logic [7:0] value);
      needs_escape = (value == FLAG_BYTE) || (value == ESC_BYTE);
   endfunction

endpackage

`default_nettype wire

// ===== design/byte_stuffing_info_framer_top.sv =====
// ----------------------------------------------------------------------------
// byte_stuffing_info_framer_top
// byte stuffing information frame transmitter
// ----------------------------------------------------------------------------
// A payload byte can be pushed every cycle while the four-entry job queue has
// room. Each byte expands to 1 to 9 line bytes (4-byte header on the first
// byte of a frame, 2 bytes for an escaped value, stuffed check and closing
// flag on the last byte), and the back-end sequencer emits one line byte per
// cycle while the result stage is free or being popped. With the framer idle,
// the first line byte of a pushed byte passes through the queue entry and then
// the result register before it reaches the result ports. Header registers
// take effect for frames whose first byte is accepted after the write.
`default_nettype none

module byte_stuffing_info_framer_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write_enable,
   input  wire logic [bsif_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [7:0]                       csr_write_data,
   input  wire logic                             push,
   output logic                                  full,
   input  wire logic [7:0]                       req_data_byte,
   input  wire logic                             req_last_byte,
   output logic                                  empty,
   input  wire logic                             pop,
   output logic [7:0]                            rsp_line_byte,
   output logic                                  rsp_frame_end
);
   import bsif_pkg::*;

   job_type front_job;
   job_type head_job;
   logic    accept;
   logic    queue_empty;
   logic    queue_pop;

   assign accept = push && !full;

   bsif_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .data_byte        (req_data_byte),
      .last_byte        (req_last_byte),
      .job              (front_job)
   );

   bsif_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_job (front_job),
      .full     (full),
      .pop      (queue_pop),
      .empty    (queue_empty),
      .head_job (head_job)
   );

   bsif_back u_back (
      .clock         (clock),
      .reset         (reset),
      .job_empty     (queue_empty),
      .job           (head_job),
      .job_pop       (queue_pop),
      .rsp_pop       (pop),
      .rsp_empty     (empty),
      .rsp_line_byte (rsp_line_byte),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

`default_nettype wire

// ===== design/bsif_front.sv =====
// ----------------------------------------------------------------------------
// bsif_front
// accepts payload bytes, holds the header registers and running check,
// and builds one job per byte for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module bsif_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write_enable,
   input  wire logic [bsif_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [7:0]                       csr_write_data,
   input  wire logic                             accept,
   input  wire logic [7:0]                       data_byte,
   input  wire logic                             last_byte,
   output bsif_pkg::job_type                     job
);
   import bsif_pkg::*;

   logic [7:0] address_ff, address_in;
   logic [7:0] control_ff, control_in;
   logic       header_sent_ff, header_sent_in;
   logic [7:0] check_ff, check_in;
   logic [7:0] check_next;

   always_comb begin
      address_in = address_ff;
      control_in = control_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_ADDRESS: address_in = csr_write_data;
            CSR_CONTROL: control_in = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   assign check_next = (header_sent_ff ? check_ff : 8'h00) ^ data_byte;

   always_comb begin
      header_sent_in = header_sent_ff;
      check_in       = check_ff;
      if (accept) begin
         header_sent_in = !last_byte;
         check_in       = last_byte ? 8'h00 : check_next;
      end
   end

   always_comb begin
      job.header  = !header_sent_ff;
      job.last    = last_byte;
      job.address = address_ff;
      job.control = control_ff;
      job.data    = data_byte;
      job.check   = check_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         address_ff     <= ADDRESS_RESET;
         control_ff     <= CONTROL_RESET;
         header_sent_ff <= 1'b0;
         check_ff       <= 8'h00;
      end else begin
         address_ff     <= address_in;
         control_ff     <= control_in;
         header_sent_ff <= header_sent_in;
         check_ff       <= check_in;
      end
   end

   `include "assert_macros.svh"

   `ASSERT_NEXT(a_last_closes, clock, reset, accept && last_byte, !header_sent_ff, "frame not closed")
   `ASSERT_NEXT(a_check_cleared, clock, reset, accept && last_byte, check_ff == 8'h00, "check kept")

endmodule

`default_nettype wire

// ===== design/bsif_queue.sv =====
// ----------------------------------------------------------------------------
// bsif_queue
// short first-word-fall-through job queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module bsif_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire bsif_pkg::job_type push_job,
   output logic                   full,
   input  wire logic              pop,
   output logic                   empty,
   output bsif_pkg::job_type      head_job
);
   import bsif_pkg::*;

   job_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `include "assert_macros.svh"

   `ASSERT_NEVER(a_pop_empty, clock, reset, pop && empty, "pop from empty queue")
   `ASSERT_NEVER(a_push_full, clock, reset, push && full, "push into full queue")

endmodule

`default_nettype wire

// ===== design/bsif_back.sv =====
// ----------------------------------------------------------------------------
// bsif_back
// sequences each job into line bytes with stuffing into a registered result stage,
// one byte per cycle while that stage is free or being popped
// ----------------------------------------------------------------------------
`default_nettype none

module bsif_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              job_empty,
   input  wire bsif_pkg::job_type job,
   output logic                   job_pop,
   input  wire logic              rsp_pop,
   output logic                   rsp_empty,
   output logic [7:0]             rsp_line_byte,
   output logic                   rsp_frame_end
);
   import bsif_pkg::*;

   localparam logic [3:0] PH_START = 4'd0;
   localparam logic [3:0] PH_FLAG  = 4'd1;
   localparam logic [3:0] PH_ADDR  = 4'd2;
   localparam logic [3:0] PH_CTRL  = 4'd3;
   localparam logic [3:0] PH_HXOR  = 4'd4;
   localparam logic [3:0] PH_DATA  = 4'd5;
   localparam logic [3:0] PH_DESC  = 4'd6;
   localparam logic [3:0] PH_CHK   = 4'd7;
   localparam logic [3:0] PH_CESC  = 4'd8;
   localparam logic [3:0] PH_END   = 4'd9;

   logic [3:0] phase_ff, phase_in;
   logic [3:0] phase_cur;
   logic [3:0] phase_next;
   logic       done;
   logic       emit;
   logic       out_free;
   logic [7:0] byte_cur;
   logic       end_cur;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff;
   logic       out_end_ff;

   assign out_free = !out_valid_ff || rsp_pop;
   assign emit     = out_free && !job_empty;
   assign phase_cur = (phase_ff == PH_START) ? (job.header ? PH_FLAG : PH_DATA) : phase_ff;

   always_comb begin
      byte_cur   = FLAG_BYTE;
      end_cur    = 1'b0;
      phase_next = PH_START;
      done       = 1'b0;
      case (phase_cur)
         PH_FLAG: begin
            byte_cur   = FLAG_BYTE;
            phase_next = PH_ADDR;
         end
         PH_ADDR: begin
            byte_cur   = job.address;
            phase_next = PH_CTRL;
         end
         PH_CTRL: begin
            byte_cur   = job.control;
            phase_next = PH_HXOR;
         end
         PH_HXOR: begin
            byte_cur   = job.address ^ job.control;
            phase_next = PH_DATA;
         end
         PH_DATA: begin
            if (needs_escape(job.data)) begin
               byte_cur   = ESC_BYTE;
               phase_next = PH_DESC;
            end else begin
               byte_cur   = job.data;
               phase_next = job.last ? PH_CHK : PH_START;
               done       = !job.last;
            end
         end
         PH_DESC: begin
            byte_cur   = job.data ^ ESC_MASK;
            phase_next = job.last ? PH_CHK : PH_START;
            done       = !job.last;
         end
         PH_CHK: begin
            if (needs_escape(job.check)) begin
               byte_cur   = ESC_BYTE;
               phase_next = PH_CESC;
            end else begin
               byte_cur   = job.check;
               phase_next = PH_END;
            end
         end
         PH_CESC: begin
            byte_cur   = job.check ^ ESC_MASK;
            phase_next = PH_END;
         end
         PH_END: begin
            byte_cur   = FLAG_BYTE;
            end_cur    = 1'b1;
            phase_next = PH_START;
            done       = 1'b1;
         end
         default: begin
            phase_next = PH_START;
         end
      endcase
   end

   assign job_pop  = emit && done;
   assign phase_in = emit ? phase_next : phase_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_byte_ff <= byte_cur;
         out_end_ff  <= end_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_line_byte = out_byte_ff;
   assign rsp_frame_end = out_end_ff;

   `include "assert_macros.svh"

   `ASSERT_IMPLY(a_end_is_flag, clock, reset, !rsp_empty && rsp_frame_end, rsp_line_byte == FLAG_BYTE, "frame end not on flag")
   `ASSERT_NEXT(a_escape_follows, clock, reset, emit && (phase_next == PH_DESC || phase_next == PH_CESC), phase_ff == PH_DESC || phase_ff == PH_CESC, "escape second byte lost")

endmodule

`default_nettype wire
